// ----- design/sss_pkg.sv -----
// Shared types, constants and functions of the seven-segment scan controller.
`timescale 1ns / 1ps
package sss_pkg;

  // Request codes of the input word.
  localparam logic [2:0] REQ_ADDR  = 3'd0;
  localparam logic [2:0] REQ_DATA  = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_LIGHT = 3'd3;
  localparam logic [2:0] REQ_PROX  = 3'd4;
  localparam logic [2:0] REQ_SCAN  = 3'd5;

  // Classified operation that travels through the queue.
  typedef enum logic [2:0] {
    OP_ADDR,
    OP_DATA,
    OP_STOP,
    OP_LIGHT,
    OP_PROX,
    OP_SCAN,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] bus_byte;
    logic [7:0] sample;
  } entry_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic              full;
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  // Receive buffer.
  localparam int RECEIVE_DEPTH = 31;
  localparam int RPOS_W        = 5;
  localparam int KEPT_BYTES    = 5;
  localparam int KEPT_IDX_W    = $clog2(KEPT_BYTES);
  localparam logic [7:0] CMD_LOAD_DIGITS = 8'h30;

  localparam int NUM_DIGITS = 4;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam logic [3:0] DIGIT_RESET [NUM_DIGITS] = '{4'd1, 4'd2, 4'd3, 4'd4};

  localparam logic [15:0] HOLD_RESET = 16'd500;

  // Configuration registers.
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_DARK_THR  = 2'd0;
  localparam logic [1:0] REG_NEAR_THR  = 2'd1;
  localparam logic [1:0] REG_HOLD_SMPL = 2'd2;
  localparam logic [7:0]  DARK_THR_RESET  = 8'd75;
  localparam logic [7:0]  NEAR_THR_RESET  = 8'd235;
  localparam logic [15:0] HOLD_SMPL_RESET = 16'd12500;

  // Active-low segment pattern; values above nine are blank.
  function automatic logic [7:0] seg_pattern(input logic [3:0] v);
    logic [7:0] p;
    unique case (v)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = 8'hFF;
    endcase
    return p;
  endfunction

endpackage

// ----- design/sss_in_if.sv -----
// Input channel interface: one event word per handshake.
`timescale 1ns / 1ps
interface sss_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic [7:0] sensor_sample;

  modport source (output valid, output req_type, output data_byte, output sensor_sample,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input sensor_sample,
                output ready);
endinterface

// ----- design/sss_out_if.sv -----
// Result channel interface: one digit drive word per handshake.
`timescale 1ns / 1ps
interface sss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_pattern;
  logic [1:0] digit_index;
  logic       digit_lit;

  modport source (output valid, output segment_pattern, output digit_index,
                  output digit_lit, input ready);
  modport sink (input valid, input segment_pattern, input digit_index, input digit_lit,
                output ready);
endinterface

// ----- design/sss_front.sv -----
// Front end: accepts event words, classifies them and pushes them into the queue.
`timescale 1ns / 1ps
module sss_front (
  sss_in_if.sink           in_chan,
  input  sss_pkg::qstat_t  q_stat,
  output logic             push,
  output sss_pkg::entry_t  push_entry
);

  sss_pkg::op_t op;

  always_comb begin
    unique case (in_chan.req_type)
      sss_pkg::REQ_ADDR:  op = sss_pkg::OP_ADDR;
      sss_pkg::REQ_DATA:  op = sss_pkg::OP_DATA;
      sss_pkg::REQ_STOP:  op = sss_pkg::OP_STOP;
      sss_pkg::REQ_LIGHT: op = sss_pkg::OP_LIGHT;
      sss_pkg::REQ_PROX:  op = sss_pkg::OP_PROX;
      sss_pkg::REQ_SCAN:  op = sss_pkg::OP_SCAN;
      default:            op = sss_pkg::OP_NONE;
    endcase
  end

  assign in_chan.ready = !q_stat.full;

  // Unused codes are taken and dropped here. A stop stores a zero terminator.
  assign push               = in_chan.valid && !q_stat.full && (op != sss_pkg::OP_NONE);
  assign push_entry.op       = op;
  assign push_entry.bus_byte = (op == sss_pkg::OP_STOP) ? 8'h00 : in_chan.data_byte;
  assign push_entry.sample   = in_chan.sensor_sample;

endmodule

// ----- design/sss_queue.sv -----
// Short queue of classified events between the front and back ends.
`timescale 1ns / 1ps
module sss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sss_pkg::entry_t  push_entry,
  input  logic             pop,
  output sss_pkg::entry_t  head,
  output sss_pkg::qstat_t  q_stat
);

  sss_pkg::entry_t                slot_r [sss_pkg::QUEUE_DEPTH];
  logic [sss_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [sss_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [sss_pkg::QCNT_W-1:0]     count_r, count_nxt;

  function automatic logic [sss_pkg::QPTR_W-1:0] ptr_inc(input logic [sss_pkg::QPTR_W-1:0] p);
    logic [sss_pkg::QPTR_W-1:0] r;
    if (p == sss_pkg::QPTR_W'(sss_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head              = slot_r[rd_ptr_r];
  assign q_stat.full       = (count_r == sss_pkg::QCNT_W'(sss_pkg::QUEUE_DEPTH));
  assign q_stat.head_valid = (count_r != '0);
  assign q_stat.count      = count_r;

endmodule

// ----- design/sss_back.sv -----
// Back end: executes queued events on the display state and registers scan results.
`timescale 1ns / 1ps
module sss_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sss_pkg::entry_t  head,
  input  sss_pkg::qstat_t  q_stat,
  input  logic [7:0]       dark_thr,
  input  logic [7:0]       near_thr,
  input  logic [15:0]      hold_smpl,
  output logic             pop,
  sss_out_if.source        out_chan
);

  logic [3:0]                     digit_r [sss_pkg::NUM_DIGITS];
  logic [3:0]                     digit_nxt [sss_pkg::NUM_DIGITS];
  logic [7:0]                     rx_byte_r [sss_pkg::KEPT_BYTES];
  logic [7:0]                     rx_byte_nxt [sss_pkg::KEPT_BYTES];
  logic [sss_pkg::RPOS_W-1:0]     rx_pos_r, rx_pos_nxt;
  logic                           dark_r, dark_nxt;
  logic                           ovr_r, ovr_nxt;
  logic [15:0]                    hold_r, hold_nxt;
  logic [sss_pkg::DIG_IDX_W-1:0]  scan_r, scan_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [7:0]                     out_seg_r, out_seg_nxt;
  logic [1:0]                     out_idx_r, out_idx_nxt;
  logic                           out_lit_r, out_lit_nxt;
  logic [15:0]                    hold_dec;

  // A scan result may only move when the output register is free or being drained.
  assign pop = q_stat.head_valid &&
               ((head.op != sss_pkg::OP_SCAN) || !out_valid_r || out_chan.ready);

  assign hold_dec = (hold_r != 16'd0) ? hold_r - 16'd1 : 16'd0;

  always_comb begin
    digit_nxt     = digit_r;
    rx_byte_nxt   = rx_byte_r;
    rx_pos_nxt    = rx_pos_r;
    dark_nxt      = dark_r;
    ovr_nxt       = ovr_r;
    hold_nxt      = hold_r;
    scan_nxt      = scan_r;
    out_seg_nxt   = out_seg_r;
    out_idx_nxt   = out_idx_r;
    out_lit_nxt   = out_lit_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    if (pop) begin
      unique case (head.op)
        sss_pkg::OP_ADDR: begin
          rx_pos_nxt = '0;
        end
        sss_pkg::OP_DATA, sss_pkg::OP_STOP: begin
          if (rx_pos_r < sss_pkg::RPOS_W'(sss_pkg::RECEIVE_DEPTH)) begin
            if (rx_pos_r < sss_pkg::RPOS_W'(sss_pkg::KEPT_BYTES)) begin
              rx_byte_nxt[rx_pos_r[sss_pkg::KEPT_IDX_W-1:0]] = head.bus_byte;
            end
            rx_pos_nxt = rx_pos_r + 1'b1;
          end
          // The command sees the buffer including the terminator just stored.
          if (head.op == sss_pkg::OP_STOP && rx_byte_nxt[0] == sss_pkg::CMD_LOAD_DIGITS) begin
            for (int i = 0; i < sss_pkg::NUM_DIGITS; i++) begin
              digit_nxt[i] = rx_byte_nxt[i + 1][3:0];
            end
          end
        end
        sss_pkg::OP_LIGHT: begin
          dark_nxt = (head.sample > dark_thr);
        end
        sss_pkg::OP_PROX: begin
          if (head.sample <= near_thr) begin
            ovr_nxt  = 1'b1;
            hold_nxt = hold_smpl;
          end else begin
            hold_nxt = hold_dec;
            if (hold_dec == 16'd0) begin
              ovr_nxt = 1'b0;
            end
          end
        end
        sss_pkg::OP_SCAN: begin
          out_valid_nxt = 1'b1;
          out_seg_nxt   = sss_pkg::seg_pattern(digit_r[scan_r]);
          out_idx_nxt   = 2'(scan_r);
          out_lit_nxt   = dark_r | ovr_r;
          scan_nxt      = scan_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r     <= sss_pkg::DIGIT_RESET;
      rx_byte_r   <= '{default: 8'h00};
      rx_pos_r    <= '0;
      dark_r      <= 1'b1;
      ovr_r       <= 1'b1;
      hold_r      <= sss_pkg::HOLD_RESET;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      digit_r     <= digit_nxt;
      rx_byte_r   <= rx_byte_nxt;
      rx_pos_r    <= rx_pos_nxt;
      dark_r      <= dark_nxt;
      ovr_r       <= ovr_nxt;
      hold_r      <= hold_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_seg_r <= out_seg_nxt;
    out_idx_r <= out_idx_nxt;
    out_lit_r <= out_lit_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.segment_pattern = out_seg_r;
  assign out_chan.digit_index     = out_idx_r;
  assign out_chan.digit_lit       = out_lit_r;

endmodule

// ----- design/seven_segment_scan_with_auto_blank.sv -----
// Top level of the four-digit seven-segment scan controller with automatic blanking.
`timescale 1ns / 1ps
// Usage:
// Events arrive on in_chan, one word per valid/ready handshake: bus address match,
// bus data byte, bus stop, light sample, proximity sample or scan tick. Codes six
// and seven are taken and ignored. Only a scan tick produces a result word on
// out_chan, carrying the active-low segment pattern, the digit index and the lit
// flag; all other events only update internal state.
// A front end classifies each word and pushes it into a two-entry queue; a back
// end pops one entry per cycle while no scan tick waits on the output register,
// updates the display state and loads the output register. A scan result passes
// through a queue slot, then the output register. While the receiver keeps up, the
// pop sustains one word per cycle; in_chan.ready drops only when the queue is full.
// When the receiver holds out_chan.ready low, the output register keeps its word,
// non-scan events keep draining, and a scan tick waits at the queue head until
// the register frees; the front keeps accepting until the queue fills. A synchronous
// active-low reset empties the queue and output register, restores digits 1-2-3-4,
// a lit display, a hold count of 500 and the register defaults. Write registers
// over the APB-style port only while the block is idle; the block does not check.
module seven_segment_scan_with_auto_blank (
  input  logic                          clk,
  input  logic                          rst_n,
  sss_in_if.sink                        in_chan,
  sss_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             push;
  sss_pkg::entry_t  push_entry;
  logic             pop;
  sss_pkg::entry_t  head;
  sss_pkg::qstat_t  q_stat;

  logic [7:0]  dark_thr_r, dark_thr_nxt;
  logic [7:0]  near_thr_r, near_thr_nxt;
  logic [15:0] hold_smpl_r, hold_smpl_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_sel;

  // Configuration registers. The word index is the address divided by four.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[3:2];

  always_comb begin
    dark_thr_nxt  = dark_thr_r;
    near_thr_nxt  = near_thr_r;
    hold_smpl_nxt = hold_smpl_r;
    if (cfg_wr) begin
      unique case (cfg_sel)
        sss_pkg::REG_DARK_THR:  dark_thr_nxt  = pwdata[7:0];
        sss_pkg::REG_NEAR_THR:  near_thr_nxt  = pwdata[7:0];
        sss_pkg::REG_HOLD_SMPL: hold_smpl_nxt = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      sss_pkg::REG_DARK_THR:  prdata = {24'd0, dark_thr_r};
      sss_pkg::REG_NEAR_THR:  prdata = {24'd0, near_thr_r};
      sss_pkg::REG_HOLD_SMPL: prdata = {16'd0, hold_smpl_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r  <= sss_pkg::DARK_THR_RESET;
      near_thr_r  <= sss_pkg::NEAR_THR_RESET;
      hold_smpl_r <= sss_pkg::HOLD_SMPL_RESET;
    end else begin
      dark_thr_r  <= dark_thr_nxt;
      near_thr_r  <= near_thr_nxt;
      hold_smpl_r <= hold_smpl_nxt;
    end
  end

  sss_front u_front (
    .in_chan    (in_chan),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  sss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .dark_thr  (dark_thr_r),
    .near_thr  (near_thr_r),
    .hold_smpl (hold_smpl_r),
    .pop       (pop),
    .out_chan  (out_chan)
  );

  // The queue never holds more entries than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= sss_pkg::QCNT_W'(sss_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  // An event that makes no result never waits at the queue head.
  a_nonscan_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.head_valid && head.op != sss_pkg::OP_SCAN) |-> pop)
    else $error("non-scan event stalled at queue head");

  // Nothing is popped from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.head_valid)
    else $error("pop from empty queue");

  // Leaving reset, no result word is pending.
  a_reset_out: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the seven-segment scan controller: directed table, then random phases.
`timescale 1ns / 1ps
module testbench;
  import sss_pkg::*;

  // Request codes six and seven are taken by the block and dropped without a result.
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  localparam logic [7:0] BLANK_PATTERN = 8'hFF;
  localparam logic [7:0] SEGMENT_LUT [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                               8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

  localparam int NUM_PHASES    = 7;
  localparam int PHASE_WORDS   = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLDOFF  = 300;
  localparam int FLOOD_TICKS   = 40;
  localparam int DIRECTED_ROWS = 25;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [7:0] pattern;
    logic [1:0] digit;
    logic       lit;
  } result_t;

  // One event word as it enters the block.
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic [7:0] sample;
  } in_word_t;

  // A row of the directed table; typed rows carry the result word written out by hand.
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] data;
    logic [7:0] sample;
    logic       typed;
    result_t    word;
  } plan_row_t;

  localparam result_t NO_WORD = '0;

  // The directed part runs with the reset configuration: digits 1-2-3-4, display lit.
  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    // Scan all four reset digits and watch the index wrap.
    '{REQ_SCAN,  8'h00, 8'h00, 1'b1, '{8'hF9, 2'd0, 1'b1}},
    '{REQ_SCAN,  8'hFF, 8'hFF, 1'b1, '{8'hA4, 2'd1, 1'b1}},
    '{REQ_SCAN,  8'h00, 8'hFF, 1'b1, '{8'hB0, 2'd2, 1'b1}},
    '{REQ_SCAN,  8'hFF, 8'h00, 1'b1, '{8'h99, 2'd3, 1'b1}},
    // Unused request codes are swallowed without a result.
    '{REQ_RSVD6, 8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{REQ_RSVD7, 8'h00, 8'h00, 1'b0, NO_WORD},
    // A full load-digits message: 0, 11 (blank), 9, 15 (blank).
    '{REQ_ADDR,  8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{REQ_DATA,  8'h30, 8'h00, 1'b0, NO_WORD},
    '{REQ_DATA,  8'hA0, 8'hFF, 1'b0, NO_WORD},
    '{REQ_DATA,  8'hFB, 8'h00, 1'b0, NO_WORD},
    '{REQ_DATA,  8'h09, 8'hFF, 1'b0, NO_WORD},
    '{REQ_DATA,  8'hFF, 8'h00, 1'b0, NO_WORD},
    '{REQ_STOP,  8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b1, '{8'hC0, 2'd0, 1'b1}},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b1, '{8'hFF, 2'd1, 1'b1}},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b1, '{8'h90, 2'd2, 1'b1}},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b1, '{8'hFF, 2'd3, 1'b1}},
    // Brightest light sample, then one far proximity sample counting the hold down.
    '{REQ_LIGHT, 8'hFF, 8'h00, 1'b0, NO_WORD},
    '{REQ_PROX,  8'h00, 8'hFF, 1'b0, NO_WORD},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b0, NO_WORD},
    '{REQ_LIGHT, 8'h00, 8'hFF, 1'b0, NO_WORD},
    // A message with an unknown command leaves the digits alone.
    '{REQ_ADDR,  8'h00, 8'h00, 1'b0, NO_WORD},
    '{REQ_DATA,  8'h31, 8'h00, 1'b0, NO_WORD},
    '{REQ_STOP,  8'h00, 8'h00, 1'b0, NO_WORD},
    '{REQ_SCAN,  8'h00, 8'h00, 1'b0, NO_WORD}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sss_in_if  in_chan_if ();
  sss_out_if out_chan_if ();

  seven_segment_scan_with_auto_blank u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the display controller, advanced once per accepted event word.
  logic [7:0]  dark_thr  = DARK_THR_RESET;
  logic [7:0]  near_thr  = NEAR_THR_RESET;
  logic [15:0] hold_smpl = HOLD_SMPL_RESET;
  logic [3:0]  digit_val [NUM_DIGITS] = DIGIT_RESET;
  logic [7:0]  rx_bytes [KEPT_BYTES] = '{default: 8'h00};
  logic [4:0]  rx_pos    = '0;
  logic        dark_flag = 1'b1;
  logic        presence  = 1'b1;
  logic [15:0] hold_cnt  = HOLD_RESET;
  logic [1:0]  scan_pos  = '0;

  // Digit drive words the block still owes, oldest first.
  result_t pending_digits [$];
  int      mismatch_count = 0;

  // Idling knobs, changed per phase by the stimulus.
  int unsigned in_gap_max    = 4;
  int unsigned out_stall_max = 4;
  bit          long_holdoff_req = 1'b0;

  // Store one byte of a bus message. Bytes past the five that a command can read only
  // move the position, and nothing moves once the buffer is full.
  task automatic buffer_byte(input logic [7:0] b);
    if (rx_pos >= RECEIVE_DEPTH) return;
    if (rx_pos < KEPT_BYTES) rx_bytes[rx_pos] = b;
    rx_pos = rx_pos + 5'd1;
  endtask

  // Apply one event word to the shadow state; a scan tick returns the digit drive word.
  task automatic advance_display(input logic [2:0] req, input logic [7:0] data,
                                 input logic [7:0] sample, output bit has_word,
                                 output result_t word);
    has_word = 1'b0;
    word = NO_WORD;
    case (req)
      REQ_ADDR: rx_pos = '0;
      REQ_DATA: buffer_byte(data);
      REQ_STOP: begin
        // The terminator goes in first, so a short message can clear a digit byte.
        buffer_byte(8'h00);
        if (rx_bytes[0] == CMD_LOAD_DIGITS) begin
          for (int i = 0; i < NUM_DIGITS; i++) digit_val[i] = rx_bytes[i + 1][3:0];
        end
      end
      REQ_LIGHT: dark_flag = (sample <= dark_thr) ? 1'b0 : 1'b1;
      REQ_PROX: begin
        if (sample <= near_thr) begin
          presence = 1'b1;
          hold_cnt = hold_smpl;
        end else begin
          // The count stops at zero rather than wrapping round.
          if (hold_cnt != 16'd0) hold_cnt = hold_cnt - 16'd1;
          if (hold_cnt == 16'd0) presence = 1'b0;
        end
      end
      REQ_SCAN: begin
        has_word = 1'b1;
        word.pattern = (digit_val[scan_pos] < 4'd10) ? SEGMENT_LUT[digit_val[scan_pos]]
                                                      : BLANK_PATTERN;
        word.digit = scan_pos;
        word.lit = dark_flag | presence;
        scan_pos = scan_pos + 2'd1;
      end
      default: ;
    endcase
  endtask

  // Offer one event word after a random gap and hold it until the block takes it.
  // Valid is only lowered when there is a gap, so back-to-back words keep it high.
  task automatic send_word(input logic [2:0] req, input logic [7:0] data,
                           input logic [7:0] sample, input logic typed,
                           input result_t typed_word);
    int unsigned gap;
    bit          has_word;
    result_t     word;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan_if.valid         <= 1'b1;
    in_chan_if.req_type      <= req;
    in_chan_if.data_byte     <= data;
    in_chan_if.sensor_sample <= sample;
    do @(posedge clk); while (!in_chan_if.ready);
    advance_display(req, data, sample, has_word, word);
    if (has_word) pending_digits.push_back(typed ? typed_word : word);
  endtask

  // Stop offering words, wait for every owed result and give the pipeline time to empty.
  task automatic settle();
    in_chan_if.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, access phase until pready, then an idle phase.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DARK_THR:  dark_thr  = value[7:0];
      REG_NEAR_THR:  near_thr  = value[7:0];
      REG_HOLD_SMPL: hold_smpl = value[15:0];
      default: ;
    endcase
  endtask

  function automatic in_word_t pack_word(logic [2:0] req, logic [7:0] data, logic [7:0] sample);
    in_word_t w;
    w.req = req;
    w.data = data;
    w.sample = sample;
    return w;
  endfunction

  // Build one random burst and send it. Most bursts are bus messages, scan ticks or
  // sensor runs with random content; a few are stray words of any code.
  task automatic random_burst(inout int counted);
    in_word_t    burst [$];
    int unsigned kind;
    int unsigned n;
    int          s;
    logic [7:0]  b;
    logic [3:0]  nib;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      // Bus message. Sometimes the address match is missing, so the position carries
      // over; lengths run from short (stale bytes stay) to well past the buffer end.
      if ($urandom_range(0, 9) != 0)
        burst.push_back(pack_word(REQ_ADDR, 8'($urandom), 8'($urandom)));
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_LOAD_DIGITS;
      burst.push_back(pack_word(REQ_DATA, b, 8'($urandom)));
      case ($urandom_range(0, 9))
        0, 1:    n = $urandom_range(0, 3);
        2:       n = $urandom_range(5, 36);
        default: n = 4;
      endcase
      repeat (n) begin
        nib = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        burst.push_back(pack_word(REQ_DATA, {4'($urandom), nib}, 8'($urandom)));
      end
      if ($urandom_range(0, 9) != 0)
        burst.push_back(pack_word(REQ_STOP, 8'($urandom), 8'($urandom)));
    end else if (kind < 55) begin
      repeat ($urandom_range(1, 8))
        burst.push_back(pack_word(REQ_SCAN, 8'($urandom), 8'($urandom)));
    end else if (kind < 70) begin
      // Light samples, half of them within two counts of the threshold.
      repeat ($urandom_range(1, 3)) begin
        s = int'(dark_thr) + int'($urandom_range(0, 4)) - 2;
        if (s < 0) s = 0;
        if (s > 255) s = 255;
        b = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'(s);
        burst.push_back(pack_word(REQ_LIGHT, 8'($urandom), b));
      end
    end else if (kind < 90) begin
      // Proximity runs lean far, so short holds run out and the override drops.
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 9))
          0:       b = near_thr;
          1, 2:    b = 8'($urandom_range(0, near_thr));
          default: b = (near_thr == 8'hFF) ? 8'($urandom)
                                           : 8'($urandom_range(near_thr + 1, 255));
        endcase
        burst.push_back(pack_word(REQ_PROX, 8'($urandom), b));
      end
    end else begin
      repeat ($urandom_range(1, 4))
        burst.push_back(pack_word(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom)));
    end
    foreach (burst[i]) begin
      send_word(burst[i].req, burst[i].data, burst[i].sample, 1'b0, NO_WORD);
      if (burst[i].req != REQ_RSVD6 && burst[i].req != REQ_RSVD7) counted++;
    end
  endtask

  // Receiver: stalls a random number of cycles before each word, and once for a long
  // stretch when the stimulus asks, so that the queue fills and the input stalls.
  initial begin : digit_receiver
    int unsigned stall;
    out_chan_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_holdoff_req) begin
        stall = LONG_HOLDOFF;
        long_holdoff_req = 1'b0;
      end else begin
        stall = $urandom_range(0, out_stall_max);
      end
      if (stall != 0) begin
        out_chan_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan_if.ready <= 1'b1;
      do @(posedge clk); while (!out_chan_if.valid);
    end
  end

  // Each accepted digit drive word is checked against the oldest owed word.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan_if.valid && out_chan_if.ready) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: segment_pattern %h digit_index %0d digit_lit %0b",
               out_chan_if.segment_pattern, out_chan_if.digit_index, out_chan_if.digit_lit);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_chan_if.segment_pattern !== want.pattern) begin
          $error("segment_pattern: expected %h, got %h", want.pattern,
                 out_chan_if.segment_pattern);
          mismatch_count++;
        end
        if (out_chan_if.digit_index !== want.digit) begin
          $error("digit_index: expected %0d, got %0d", want.digit, out_chan_if.digit_index);
          mismatch_count++;
        end
        if (out_chan_if.digit_lit !== want.lit) begin
          $error("digit_lit: expected %0b, got %0b", want.lit, out_chan_if.digit_lit);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int          counted;
    logic [7:0]  dark_v;
    logic [7:0]  near_v;
    logic [15:0] hold_v;
    rst_n                    <= 1'b0;
    in_chan_if.valid         <= 1'b0;
    in_chan_if.req_type      <= REQ_ADDR;
    in_chan_if.data_byte     <= 8'h00;
    in_chan_if.sensor_sample <= 8'h00;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table under the reset configuration.
    foreach (PLAN[i]) send_word(PLAN[i].req, PLAN[i].data, PLAN[i].sample, PLAN[i].typed,
                                PLAN[i].word);
    settle();

    // Random phases, each under its own register setting and idling profile.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          // Lowest dark threshold, highest near threshold, a hold of a single sample.
          dark_v = 8'd0;   near_v = 8'd255; hold_v = 16'd1;
          in_gap_max = 16; out_stall_max = 16;
        end
        1: begin
          // The opposite corner, with no idling on either side.
          dark_v = 8'd255; near_v = 8'd0;   hold_v = 16'hFFFF;
          in_gap_max = 0;  out_stall_max = 0;
        end
        2: begin
          dark_v = 8'($urandom); near_v = 8'($urandom); hold_v = 16'($urandom_range(1, 8));
          in_gap_max = 16; out_stall_max = 2;
        end
        3: begin
          dark_v = DARK_THR_RESET; near_v = NEAR_THR_RESET; hold_v = HOLD_SMPL_RESET;
          in_gap_max = 2;  out_stall_max = 16;
        end
        default: begin
          dark_v = 8'($urandom); near_v = 8'($urandom); hold_v = 16'($urandom_range(1, 40));
          in_gap_max = 16; out_stall_max = 16;
        end
      endcase
      cfg_write(REG_DARK_THR,  {24'd0, dark_v});
      cfg_write(REG_NEAR_THR,  {24'd0, near_v});
      cfg_write(REG_HOLD_SMPL, {16'd0, hold_v});

      if (p == 2) begin
        // Flood scan ticks while the receiver holds off, so the input has to stall.
        long_holdoff_req = 1'b1;
        in_gap_max = 0;
        repeat (FLOOD_TICKS) send_word(REQ_SCAN, 8'($urandom), 8'($urandom), 1'b0, NO_WORD);
        settle();
        in_gap_max = 16;
      end

      counted = 0;
      while (counted < PHASE_WORDS) begin
        random_burst(counted);
        if ($urandom_range(0, 39) == 0) settle();
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/sss_pkg.sv
design/sss_in_if.sv
design/sss_out_if.sv
design/sss_front.sv
design/sss_queue.sv
design/sss_back.sv
design/seven_segment_scan_with_auto_blank.sv
tb/testbench.sv
